### rtl/hebp_pkg.sv
// Shared types and constants for the Huffman encoder bit packer.
package hebp_pkg;

  localparam int SYM_W       = 8;
  localparam int CODE_W      = 32;
  localparam int LEN_FIELD_W = 6;
  localparam int PEND_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int PAD_W       = 3;
  localparam int MAX_OUT     = 4;
  localparam int ACC_W       = PEND_W + CODE_W;
  localparam int WIN_W       = MAX_OUT * BYTE_W;
  localparam int TOT_W       = 6;
  localparam int CNT_W       = 3;

  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_NUM_SYMBOLS  = 256;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  // One packed item handed to the output buffer.
  typedef struct packed {
    logic [WIN_W-1:0] win;
    logic [CNT_W-1:0] count;
    logic             byte_valid;
    logic [PAD_W-1:0] pad;
    logic             last;
  } hebp_res_t;

endpackage

### rtl/hebp_ram.sv
// Generic single write port, single read port RAM with registered read.
module hebp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hebp_table.sv
// Code table: RAM for code value and length, per-entry valid bits.
module hebp_table
  import hebp_pkg::*;
#(
  parameter int MaxCodeLen = DEF_MAX_CODE_LEN,
  parameter int NumSymbols = DEF_NUM_SYMBOLS,
  localparam int LenLimit  = (MaxCodeLen < CODE_W) ? MaxCodeLen : CODE_W,
  localparam int LenW      = $clog2(LenLimit + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic                   lookup_i,
  input  logic [SYM_W-1:0]       symbol_i,
  input  logic [CODE_W-1:0]      code_value_i,
  input  logic [LEN_FIELD_W-1:0] code_length_i,
  output logic [LenW-1:0]        code_len_o,
  output logic [CODE_W-1:0]      code_bits_o
);

  localparam int AddrW    = $clog2(NumSymbols);
  localparam int SymCmpW  = SYM_W + 1;
  localparam int EntryW   = LenW + CODE_W;

  logic [NumSymbols-1:0]  vld_q, vld_d;
  logic                   hit_q, hit_d;
  logic                   in_range;
  logic [AddrW-1:0]       addr;
  logic [LEN_FIELD_W-1:0] len_sat;
  logic [CODE_W-1:0]      code_mask;
  logic                   we;
  logic [EntryW-1:0]      wdata, rdata;

  assign in_range  = {1'b0, symbol_i} < SymCmpW'(NumSymbols);
  assign addr      = symbol_i[AddrW-1:0];
  assign len_sat   = (code_length_i > LEN_FIELD_W'(LenLimit)) ?
                     LEN_FIELD_W'(LenLimit) : code_length_i;
  // shifting by the full width leaves zero, so the mask becomes all ones
  assign code_mask = ~({CODE_W{1'b1}} << len_sat);
  assign we        = load_i & in_range;
  assign wdata     = {LenW'(len_sat), code_value_i & code_mask};

  always_comb begin
    vld_d = vld_q;
    if (we) begin
      vld_d[addr] = 1'b1;
    end
  end

  assign hit_d = lookup_i ? (in_range & vld_q[addr]) : hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      hit_q <= hit_d;
    end
  end

  hebp_ram #(
    .Width (EntryW),
    .Depth (NumSymbols)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (lookup_i),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // never written or out of range entries read as an empty code
  assign code_len_o  = hit_q ? rdata[EntryW-1:CODE_W] : '0;
  assign code_bits_o = hit_q ? rdata[CODE_W-1:0] : '0;

endmodule

### rtl/hebp_packer.sv
// Working stage: bit accumulator, byte split and flush padding.
module hebp_packer
  import hebp_pkg::*;
#(
  parameter int LenW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        op_i,
  input  logic [LenW-1:0]   code_len_i,
  input  logic [CODE_W-1:0] code_bits_i,
  input  logic              emit_ready_i,
  output logic              in_ready_o,
  output logic              push_o,
  output hebp_res_t         res_o
);

  logic              s1_valid_q, s1_valid_d;
  op_e               s1_op_q;
  logic [PEND_W-1:0] pb_q, pb_d;
  logic [CNT_W-1:0]  pc_q, pc_d;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_top;
  logic [TOT_W-1:0]  total;
  logic [WIN_W-1:0]  aligned;
  logic [PEND_W-1:0] keep_mask;
  logic [3:0]        fl_shift;
  logic [BYTE_W-1:0] fl_byte;
  logic              needs_emit;
  logic              advance;

  assign acc       = (ACC_W'(pb_q) << code_len_i) | ACC_W'(code_bits_i);
  assign total     = TOT_W'(pc_q) + TOT_W'(code_len_i);
  // earliest pending bit lands in the top bit of the window
  assign acc_top   = acc << (TOT_W'(ACC_W) - total);
  assign aligned   = acc_top[ACC_W-1 -: WIN_W];
  assign keep_mask = ~({PEND_W{1'b1}} << total[2:0]);
  assign fl_shift  = 4'(BYTE_W) - 4'(pc_q);
  assign fl_byte   = BYTE_W'({1'b0, pb_q}) << fl_shift;

  always_comb begin
    needs_emit = 1'b0;
    res_o      = '0;
    pb_d       = pb_q;
    pc_d       = pc_q;
    case (s1_op_q)
      OP_ENCODE: begin
        needs_emit       = (total[TOT_W-1:3] != '0);
        res_o.win        = aligned;
        res_o.count      = CNT_W'(total[TOT_W-1:3]);
        res_o.byte_valid = 1'b1;
        pb_d             = acc[PEND_W-1:0] & keep_mask;
        pc_d             = total[2:0];
      end
      OP_FLUSH: begin
        needs_emit       = 1'b1;
        res_o.win        = {fl_byte, {(WIN_W-BYTE_W){1'b0}}};
        res_o.count      = CNT_W'(1);
        res_o.byte_valid = (pc_q != '0);
        res_o.pad        = PAD_W'(fl_shift);
        res_o.last       = 1'b1;
        pb_d             = '0;
        pc_d             = '0;
      end
      default: begin
      end
    endcase
  end

  assign advance    = s1_valid_q & (~needs_emit | emit_ready_i);
  assign push_o     = advance & needs_emit;
  assign in_ready_o = ~s1_valid_q | advance;
  assign s1_valid_d = accept_i | (s1_valid_q & ~advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pb_q       <= '0;
      pc_q       <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        pb_q <= pb_d;
        pc_q <= pc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_op_q <= op_e'(op_i);
    end
  end

endmodule

### rtl/hebp_emitter.sv
// Output buffer: holds up to four bytes and hands out one per transaction.
module hebp_emitter
  import hebp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hebp_res_t         res_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              taken_i,
  output logic [BYTE_W-1:0] byte_o,
  output logic              byte_valid_o,
  output logic [PAD_W-1:0]  pad_o,
  output logic              last_o,
  output logic [CNT_W-1:0]  count_o
);

  logic [WIN_W-1:0] win_q, win_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             bv_q, bv_d;
  logic [PAD_W-1:0] pad_q, pad_d;
  logic             last_q, last_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & taken_i;
  assign ready_o = (cnt_q == '0) | ((cnt_q == CNT_W'(1)) & taken_i);

  always_comb begin
    win_d  = win_q;
    cnt_d  = cnt_q;
    bv_d   = bv_q;
    pad_d  = pad_q;
    last_d = last_q;
    if (push_i) begin
      win_d  = res_i.win;
      cnt_d  = res_i.count;
      bv_d   = res_i.byte_valid;
      pad_d  = res_i.pad;
      last_d = res_i.last;
    end else if (pop) begin
      win_d = win_q << BYTE_W;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    bv_q   <= bv_d;
    pad_q  <= pad_d;
    last_q <= last_d;
  end

  assign byte_o       = win_q[WIN_W-1 -: BYTE_W];
  assign byte_valid_o = bv_q;
  assign pad_o        = pad_q;
  assign last_o       = last_q;
  assign count_o      = cnt_q;

endmodule

### rtl/huffman_encode_bit_packer_core.sv
// Path: an item enters the working stage registers, then the output buffer registers.
// Throughput: one item per cycle while results are taken and each item yields at most one
//   byte; an encode completing n bytes (n <= 4) holds the single byte-wide output port
//   for n transactions. Loads and empty encodes pass the working stage and yield nothing.
// Reset (rst_ni low, async): pending bits cleared, every table length reads zero at once
//   through per-entry valid bits; no clearing pass, items are taken right after reset.
module huffman_encode_bit_packer_core
  import hebp_pkg::*;
#(
  parameter int MaxCodeLen = DEF_MAX_CODE_LEN,
  parameter int NumSymbols = DEF_NUM_SYMBOLS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input item stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [7:0] symbol, [39:8] code_value, [45:40] code_length, [47:46] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] operation
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] out_byte, [10:8] pad_bits, [15:11] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // [0] byte_valid
  output logic [M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  localparam int LenLimit = (MaxCodeLen < CODE_W) ? MaxCodeLen : CODE_W;
  localparam int LenW     = $clog2(LenLimit + 1);

  // input field split
  logic [SYM_W-1:0]       symbol;
  logic [CODE_W-1:0]      code_value;
  logic [LEN_FIELD_W-1:0] code_length;
  logic                   accept;

  assign symbol      = s_axis_tdata_i[SYM_W-1:0];
  assign code_value  = s_axis_tdata_i[SYM_W +: CODE_W];
  assign code_length = s_axis_tdata_i[SYM_W+CODE_W +: LEN_FIELD_W];
  assign accept      = s_axis_tvalid_i & s_axis_tready_o;

  // table write happens on the load transaction itself, so an encode in the
  // very next transaction already reads the new entry
  logic [LenW-1:0]   code_len;
  logic [CODE_W-1:0] code_bits;

  hebp_table #(
    .MaxCodeLen (MaxCodeLen),
    .NumSymbols (NumSymbols)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept & (s_axis_tuser_i == OP_LOAD)),
    .lookup_i      (accept & (s_axis_tuser_i == OP_ENCODE)),
    .symbol_i      (symbol),
    .code_value_i  (code_value),
    .code_length_i (code_length),
    .code_len_o    (code_len),
    .code_bits_o   (code_bits)
  );

  // working stage: accumulator update and byte split
  logic      emit_ready;
  logic      push;
  hebp_res_t res;

  hebp_packer #(
    .LenW (LenW)
  ) u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (s_axis_tuser_i),
    .code_len_i   (code_len),
    .code_bits_i  (code_bits),
    .emit_ready_i (emit_ready),
    .in_ready_o   (s_axis_tready_o),
    .push_o       (push),
    .res_o        (res)
  );

  // output buffer, drained one byte per output transaction
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic [PAD_W-1:0]  pad_bits;
  logic [CNT_W-1:0]  out_count;

  hebp_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .res_i        (res),
    .ready_o      (emit_ready),
    .valid_o      (m_axis_tvalid_o),
    .taken_i      (m_axis_tready_i),
    .byte_o       (out_byte),
    .byte_valid_o (byte_valid),
    .pad_o        (pad_bits),
    .last_o       (m_axis_tlast_o),
    .count_o      (out_count)
  );

  assign m_axis_tdata_o = M_TDATA_W'({pad_bits, out_byte});
  assign m_axis_tuser_o = M_TUSER_W'(byte_valid);

  // input stalls only because results are waiting at the output
  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with an empty output buffer");

  // an empty-data result only ever comes from an empty flush
  a_empty_is_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |->
      (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("empty result that is not an empty flush");

  // padding is reported only on the closing result
  a_pad_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[10:8] != '0) |-> m_axis_tlast_o)
    else $error("pad bits on a result that is not last");

  // one item never leaves more than four bytes
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_count <= CNT_W'(MAX_OUT))
    else $error("output buffer count out of range");

endmodule
